/* rtl/core/assert_macros.svh */
// Assertion helpers for the hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the next cycle.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sha1_pkg.sv */
`default_nettype none
package sha1_pkg;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
  } out_item_t;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    BSRC_DATA,
    BSRC_PAD,
    BSRC_ZERO,
    BSRC_LEN
  } bsrc_t;

  typedef struct packed {
    logic  byte_wr;      // write one byte at the fill pointer, advance pointer
    bsrc_t byte_src;
    logic  count_inc;    // count one message byte
    logic  load_round;   // load working vars from chain
    logic  do_round;     // run one round
    logic  add_chain;    // add working vars into chain
    logic  init_chain;   // restore IV and clear count
    logic  latch_len;    // snapshot bit length for padding
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;        // current fill pointer
    logic       last_round;
  } status_t;

endpackage
`default_nettype wire

/* rtl/core/sha1_datapath.sv */
`default_nettype none
module sha1_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha1_pkg::cmd_t     cmd,
  input  wire logic [7:0]         data_byte,
  output sha1_pkg::status_t       status,
  output sha1_pkg::out_item_t     digest
);

  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [63:0] bit_len;
  logic [31:0] chain [5];
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  round_index;
  logic [7:0]  wr_byte;
  logic [31:0] f, k, wt, wx, tmp;
  logic [2:0]  len_sel;

  assign len_sel = fill[2:0];

  always_comb begin
    unique case (cmd.byte_src)
      sha1_pkg::BSRC_DATA: wr_byte = data_byte;
      sha1_pkg::BSRC_PAD:  wr_byte = sha1_pkg::PAD_BYTE;
      sha1_pkg::BSRC_ZERO: wr_byte = 8'h00;
      sha1_pkg::BSRC_LEN:  wr_byte = bit_len[63 - 8*len_sel -: 8];
      default:             wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      byte_count <= '0;
    end else begin
      if (cmd.init_chain) begin
        fill <= '0;
        byte_count <= '0;
      end else begin
        if (cmd.byte_wr) fill <= fill + 6'd1;
        if (cmd.count_inc) byte_count <= byte_count + 64'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_len) bit_len <= {byte_count[60:0], 3'b000};
  end

  assign wx = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign wt = (round_index < 7'd16) ? w[0] : {wx[30:0], wx[31]};

  always_comb begin
    if (round_index < 7'd20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K0;
    end else if (round_index < 7'd40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (round_index < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
  end

  assign tmp = {a[26:0], a[31:27]} + f + e + k + wt;

  // Bytes land straight in the schedule words, most significant byte first.
  // During rounds the schedule is a shift line: w[0] is the current word in rounds 0 to 15.
  always_ff @(posedge clk) begin
    if (cmd.byte_wr) begin
      w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_round) begin
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
    end else if (cmd.do_round) begin
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      round_index <= '0;
    end else if (cmd.load_round) begin
      round_index <= '0;
    end else if (cmd.do_round) begin
      round_index <= round_index + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init_chain) begin
      chain[0] <= sha1_pkg::H0_INIT;
      chain[1] <= sha1_pkg::H1_INIT;
      chain[2] <= sha1_pkg::H2_INIT;
      chain[3] <= sha1_pkg::H3_INIT;
      chain[4] <= sha1_pkg::H4_INIT;
    end else if (cmd.add_chain) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  assign status.fill = fill;
  assign status.last_round = (round_index == 7'(sha1_pkg::ROUNDS - 1));

  assign digest.digest_word0 = chain[0];
  assign digest.digest_word1 = chain[1];
  assign digest.digest_word2 = chain[2];
  assign digest.digest_word3 = chain[3];
  assign digest.digest_word4 = chain[4];

endmodule
`default_nettype wire

/* rtl/core/sha1_ctrl.sv */
`default_nettype none
module sha1_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic                in_action,
  input  wire sha1_pkg::status_t   status,
  input  wire logic                out_stall,
  output sha1_pkg::cmd_t           cmd,
  output logic                     busy,
  output logic                     out_valid
);

  sha1_pkg::state_t state, state_next;
  logic finishing, finishing_next;
  logic pad_done, pad_done_next;   // 0x80 already placed
  logic length_written, length_written_next;
  logic length_spill, length_spill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::ST_IDLE;
      finishing <= 1'b0;
      pad_done <= 1'b0;
    end else begin
      state <= state_next;
      finishing <= finishing_next;
      pad_done <= pad_done_next;
    end
  end

  // Pad phase writes one byte per cycle: 0x80, zeros up to 56, then length.
  always_comb begin
    state_next = state;
    finishing_next = finishing;
    pad_done_next = pad_done;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_action == sha1_pkg::ACT_FINISH) begin
            state_next = sha1_pkg::ST_PAD;
            finishing_next = 1'b1;
            pad_done_next = 1'b0;
          end else if (status.fill == 6'd63) begin
            state_next = sha1_pkg::ST_ROUND;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        pad_done_next = 1'b1;
        if (status.fill == 6'd63) state_next = sha1_pkg::ST_ROUND;
      end
      sha1_pkg::ST_ROUND: begin
        if (status.last_round) state_next = sha1_pkg::ST_ADD;
      end
      sha1_pkg::ST_ADD: begin
        if (!finishing) state_next = sha1_pkg::ST_IDLE;
        else if (pad_done && status.fill == 6'd0 && length_written)
          state_next = sha1_pkg::ST_EMIT;
        else state_next = sha1_pkg::ST_PAD;
      end
      sha1_pkg::ST_EMIT: begin
        if (!out_stall) begin
          state_next = sha1_pkg::ST_IDLE;
          finishing_next = 1'b0;
        end
      end
      default: state_next = sha1_pkg::ST_IDLE;
    endcase
  end

  // Track whether the length field went into the block just compressed.
  always_ff @(posedge clk) begin
    if (rst) length_written <= 1'b0;
    else length_written <= length_written_next;
  end

  always_comb begin
    length_written_next = length_written;
    if (state == sha1_pkg::ST_IDLE) length_written_next = 1'b0;
    else if (state == sha1_pkg::ST_PAD && status.fill == 6'd63)
      length_written_next = pad_done && !length_spill;
  end

  always_comb begin
    cmd = '0;
    cmd.byte_src = sha1_pkg::BSRC_DATA;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_action == sha1_pkg::ACT_ABSORB) begin
            cmd.byte_wr = 1'b1;
            cmd.count_inc = 1'b1;
            if (status.fill == 6'd63) cmd.load_round = 1'b0;
          end else begin
            cmd.latch_len = 1'b1;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        cmd.byte_wr = 1'b1;
        if (!pad_done) cmd.byte_src = sha1_pkg::BSRC_PAD;
        else if (status.fill >= 6'd56 && !length_spill)
          cmd.byte_src = sha1_pkg::BSRC_LEN;
        else cmd.byte_src = sha1_pkg::BSRC_ZERO;
      end
      sha1_pkg::ST_ROUND: begin
        cmd.do_round = 1'b1;
      end
      sha1_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      sha1_pkg::ST_EMIT: begin
        if (!out_stall) cmd.init_chain = 1'b1;
      end
      default: ;
    endcase
    if (state_next == sha1_pkg::ST_ROUND && state != sha1_pkg::ST_ROUND)
      cmd.load_round = 1'b1;
  end

  // 0x80 landed at 56 or later: the length goes in a second block.
  always_ff @(posedge clk) begin
    if (rst) length_spill <= 1'b0;
    else length_spill <= length_spill_next;
  end
  always_comb begin
    length_spill_next = length_spill;
    if (state == sha1_pkg::ST_PAD && !pad_done) length_spill_next = (status.fill >= 6'd56);
    else if (state == sha1_pkg::ST_ADD) length_spill_next = 1'b0;
  end

  assign busy = (state != sha1_pkg::ST_IDLE);
  assign out_valid = (state == sha1_pkg::ST_EMIT);

endmodule
`default_nettype wire

/* rtl/core/sha1_stream_hasher.sv */
`default_nettype none
// Streaming SHA-1 engine. Bytes arrive one per transaction (action 0) and
// are packed into a 64-byte block; the 64th byte starts a compression of 80
// rounds, one round per cycle, then an add into the chaining words, during
// which no transaction is taken. A finish transaction (action 1) writes the
// padding one byte per cycle up to the block end, compresses one or two
// padded blocks, then holds the digest on the output until it is taken and
// returns to the initial chaining values. Absorb throughput is bounded by the
// single round unit; the longest finish pads two blocks (0x80 at byte 56 or
// later), and the digest then waits out any output stall.
`include "assert_macros.svh"
module sha1_stream_hasher (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sha1_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sha1_pkg::out_item_t      out_data
);

  sha1_pkg::cmd_t    cmd;
  sha1_pkg::status_t status;
  logic              busy;
  logic              in_fire;

  // Take a transaction only while no block or digest is in flight.
  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_action (in_data.action),
    .status    (status),
    .out_stall (out_stall),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sha1_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (in_data.data_byte),
    .status    (status),
    .digest    (out_data)
  );

  `CHK_IMPL(a_no_accept_busy, clk, rst, out_valid, in_stall,
            "input accepted while digest pending")
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid,
            "digest dropped while stalled")
  `CHK_IMPL(a_round_excl, clk, rst, cmd.do_round, !cmd.byte_wr,
            "buffer written during rounds")

endmodule
`default_nettype wire

/* dv/tb_sha1_stream_hasher.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_sha1_stream_hasher;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 400;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sha1_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  sha1_pkg::out_item_t out_data;

  sha1_stream_hasher DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Predictor state: chaining words, partial block and byte count.
  logic [31:0] chain_h[5];
  logic [7:0] msg_block[64];
  logic [63:0] msg_len;

  sha1_pkg::out_item_t digest_q[$];
  int unsigned error_count;
  int unsigned digest_count;
  int unsigned byte_total;
  int unsigned cycle_count = 0;

  // Percent chance of an idle cycle on each side.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Run one 80-round compression into chain_h.
  task automatic compress(input logic [7:0] blk[64]);
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = w[r];
      end else begin
        wt = rotl(w[(r-3)&15] ^ w[(r-8)&15] ^ w[(r-14)&15] ^ w[r&15], 1);
        w[r&15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d); k = sha1_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      tmp = rotl(a, 5) + f + e + k + wt;
      e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endtask

  task automatic restart_chain();
    chain_h[0] = sha1_pkg::H0_INIT; chain_h[1] = sha1_pkg::H1_INIT;
    chain_h[2] = sha1_pkg::H2_INIT; chain_h[3] = sha1_pkg::H3_INIT;
    chain_h[4] = sha1_pkg::H4_INIT;
    msg_len = '0;
  endtask

  // Advance the predictor by one accepted transaction.
  task automatic predict_hash(input sha1_pkg::in_item_t it);
    logic [7:0] pad_lo[64];
    logic [7:0] pad_hi[64];
    logic [63:0] bit_len;
    int unsigned fill;
    sha1_pkg::out_item_t dg;
    if (it.action == sha1_pkg::ACT_ABSORB) begin
      msg_block[msg_len[5:0]] = it.data_byte;
      msg_len++;
      if (msg_len[5:0] == 6'd0) compress(msg_block);
    end else begin
      fill = 32'(msg_len[5:0]);
      bit_len = msg_len << 3;
      for (int i = 0; i < 64; i++) begin
        pad_lo[i] = (i < fill) ? msg_block[i] : 8'h00;
        pad_hi[i] = 8'h00;
      end
      pad_lo[fill] = sha1_pkg::PAD_BYTE;
      for (int i = 0; i < 8; i++) begin
        if (fill < 56) pad_lo[56+i] = bit_len[63-8*i -: 8];
        else pad_hi[56+i] = bit_len[63-8*i -: 8];
      end
      compress(pad_lo);
      if (fill >= 56) compress(pad_hi);
      dg = '{chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
      digest_q.push_back(dg);
      restart_chain();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("ERROR @%0t: %s got %08h expected %08h", $time, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count cycles and kill a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("sha1_stream_hasher verification failed");
      $finish;
    end
  end

  // Randomize the receiver stall on the falling edge.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each digest transaction against the oldest expectation.
  always @(posedge clk) begin
    sha1_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      digest_count++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest_word0", out_data.digest_word0, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word0 !== want.digest_word0)
          report_mismatch("digest_word0", out_data.digest_word0, want.digest_word0);
        if (out_data.digest_word1 !== want.digest_word1)
          report_mismatch("digest_word1", out_data.digest_word1, want.digest_word1);
        if (out_data.digest_word2 !== want.digest_word2)
          report_mismatch("digest_word2", out_data.digest_word2, want.digest_word2);
        if (out_data.digest_word3 !== want.digest_word3)
          report_mismatch("digest_word3", out_data.digest_word3, want.digest_word3);
        if (out_data.digest_word4 !== want.digest_word4)
          report_mismatch("digest_word4", out_data.digest_word4, want.digest_word4);
      end
    end
  end

  // Send one transaction: optional idle gap, then hold until accepted.
  // Valid stays up after acceptance until the next call or an idle.
  task automatic send_item(input logic act, input logic [7:0] b);
    sha1_pkg::in_item_t it;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    it.action = act;
    it.data_byte = b;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_hash(it);
    if (act == sha1_pkg::ACT_ABSORB) byte_total++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(sha1_pkg::ACT_ABSORB, 8'($urandom));
    send_item(sha1_pkg::ACT_FINISH, 8'($urandom));
  endtask

  // Hold the sender until every expected digest has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_and_extremes();
    send_item(sha1_pkg::ACT_FINISH, 8'h00);
    send_item(sha1_pkg::ACT_FINISH, 8'hFF);
    // "abc" known vector, then all-zero and all-ones bytes.
    send_item(sha1_pkg::ACT_ABSORB, 8'h61);
    send_item(sha1_pkg::ACT_ABSORB, 8'h62);
    send_item(sha1_pkg::ACT_ABSORB, 8'h63);
    send_item(sha1_pkg::ACT_FINISH, 8'h00);
    send_item(sha1_pkg::ACT_ABSORB, 8'h00);
    send_item(sha1_pkg::ACT_ABSORB, 8'hFF);
    send_item(sha1_pkg::ACT_FINISH, 8'hAA);
    wait_drained();
  endtask

  // Cover padding boundaries: one block, length field spill, exact block.
  task automatic test_pad_boundaries();
    int unsigned lens[6] = '{55, 56, 63, 64, 65, 119};
    foreach (lens[i]) send_message(lens[i]);
    wait_drained();
  endtask

  task automatic test_random_messages(input int unsigned gap, input int unsigned stall,
                                      input int unsigned item_budget);
    int unsigned start;
    int unsigned len;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    start = byte_total + digest_count;
    while (byte_total + digest_count - start < item_budget) begin
      // Mostly short messages, now and then one spanning several blocks.
      len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(70);
      send_message(len);
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    digest_count = 0;
    byte_total = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    restart_chain();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_gap_pct = 6;
    recv_stall_pct = 45;
    test_empty_and_extremes();
    test_pad_boundaries();
    test_random_messages(6, 45, 270);
    test_random_messages(45, 6, 270);
    test_random_messages(0, 0, 270);

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d message bytes and %0d digests, padding boundaries and",
             byte_total, digest_count);
    $display("empty messages, under sender gaps and receiver stalls");
    if (error_count == 0 && digest_q.size() == 0) begin
      $display("sha1_stream_hasher verification clean");
    end else begin
      $display("%0d mismatches, %0d digests missing", error_count, digest_q.size());
      $display("sha1_stream_hasher verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
